// ===== hdl/wav_pcm_stream_parser_unit_defines.svh =====
// Assertion macros used by the checker file of the WAV PCM parser.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef WAV_PCM_STREAM_PARSER_UNIT_DEFINES_SVH
`define WAV_PCM_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define WPSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define WPSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wpsp_pkg.sv =====
// Package of the WAV PCM parser: beat types, tags, result and reject codes.
// No dependencies; the parser modules and the checker import it.
`default_nettype none

package wpsp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] RIFF_END_OFS  = 32'd3;
  localparam logic [31:0] WAVE_END_OFS  = 32'd11;
  localparam logic [15:0] CHDR_TAG_BYTES = 16'd4;
  localparam logic [15:0] CHDR_BYTES     = 16'd8;
  localparam logic [15:0] FMT_BYTES      = 16'd16;
  localparam logic [31:0] FMT_MIN_BYTES  = 32'd16;
  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] DEPTH_8BIT     = 16'd8;
  localparam logic [7:0]  U8_BIAS        = 8'd127;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] REJ_NOT_WAVE   = 3'd0;
  localparam logic [2:0] REJ_FMT_SHORT  = 3'd1;
  localparam logic [2:0] REJ_NOT_PCM    = 3'd2;
  localparam logic [2:0] REJ_NO_DATA    = 3'd3;
  localparam logic [2:0] REJ_BAD_ALIGN  = 3'd4;
  localparam logic [2:0] REJ_DATA_FIRST = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_beat_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_frame;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [15:0]        bits_per_sample;
    logic [2:0]         reject_code;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_beat_t;

endpackage

`default_nettype wire

// ===== hdl/wpsp_if.sv =====
// Valid/ready channel interfaces of the WAV PCM parser: byte in, result out.
// No dependencies.
`default_nettype none

interface wpsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, data_byte, start_of_file, input ready);
  modport sink   (input valid, data_byte, start_of_file, output ready);
endinterface

interface wpsp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               last_frame;
  logic [31:0]        sample_rate;
  logic [15:0]        channel_count;
  logic [15:0]        bits_per_sample;
  logic [2:0]         reject_code;

  modport source (output valid, result_kind, left_sample, right_sample, last_frame,
                  sample_rate, channel_count, bits_per_sample, reject_code,
                  input ready);
  modport sink   (input valid, result_kind, left_sample, right_sample, last_frame,
                  sample_rate, channel_count, bits_per_sample, reject_code,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/wpsp_in_stage.sv =====
// Input register of the WAV PCM parser: holds one byte beat for the parse step.
// Depends on wpsp_pkg.
`default_nettype none

module wpsp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  wpsp_pkg::item_t    in_item,
  input  logic               advance,
  output logic               in_ready,
  output wpsp_pkg::item_beat_t held
);
  import wpsp_pkg::*;

  logic  full;
  item_t item;

  // refill in the same cycle the held beat is consumed
  assign in_ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  assign held = '{valid: full, item: item};

endmodule

`default_nettype wire

// ===== hdl/wpsp_core.sv =====
// Parse step of the WAV PCM parser: chunk walk state, format fields, frame
// assembly and the result of one byte. Depends on wpsp_pkg.
`default_nettype none

module wpsp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  input  wpsp_pkg::item_beat_t   held,
  input  logic                   advance,
  output wpsp_pkg::result_beat_t res
);
  import wpsp_pkg::*;

  function automatic logic [15:0] to_sample(input logic [15:0] raw, input logic is8);
    logic [7:0] centered;
    centered = raw[7:0] - U8_BIAS;
    to_sample = is8 ? {centered, 8'h00} : raw;
  endfunction

  logic [31:0] file_size;
  phase_t      phase, phase_next;
  logic [31:0] file_offset, off_next;
  logic [31:0] cbl, cbl_next;            // chunk bytes left
  logic [31:0] tag, tag_next;
  logic [15:0] fmt_tag, fmt_tag_next;
  logic [15:0] channels, channels_next;
  logic [31:0] rate, rate_next;
  logic [15:0] align, align_next;
  logic [15:0] bits, bits_next;
  logic [15:0] idx, idx_next;
  logic [15:0] left_bytes, left_next;
  logic [15:0] right_bytes, right_next;
  logic        seen, seen_next;

  logic [7:0]  b;
  logic        sof;
  logic        active;
  logic [32:0] next_pos;
  logic        walk_fail;
  result_t     res_data;
  logic        res_valid;

  assign b      = held.item.data_byte;
  assign sof    = held.item.start_of_file;
  assign active = sof || (phase != PH_IDLE && phase != PH_DONE);

  assign off_next  = sof ? 32'd0 : (active ? file_offset + 32'd1 : file_offset);
  assign next_pos  = {1'b0, off_next} + 33'd1;
  assign walk_fail = ({1'b0, next_pos} + 34'd8) > {2'b00, file_size};

  always_comb begin
    logic        walk;
    logic        rej;
    logic [2:0]  rej_code;
    logic [1:0]  w;
    logic [16:0] need;
    logic [15:0] r;
    logic [15:0] rel;
    logic [31:0] rem;
    logic        is8;
    logic        last;

    phase_next    = phase;
    cbl_next      = cbl;
    tag_next      = tag;
    fmt_tag_next  = fmt_tag;
    channels_next = channels;
    rate_next     = rate;
    align_next    = align;
    bits_next     = bits;
    idx_next      = idx;
    left_next     = left_bytes;
    right_next    = right_bytes;
    seen_next     = seen;
    res_valid     = 1'b0;
    res_data      = '0;
    walk          = 1'b0;
    rej           = 1'b0;
    rej_code      = REJ_NOT_WAVE;
    is8           = (bits == DEPTH_8BIT);
    w             = is8 ? 2'd1 : 2'd2;
    need          = '0;
    r             = '0;
    rel           = '0;
    rem           = '0;
    last          = 1'b0;

    if (sof) begin
      phase_next = PH_HEADER;
      cbl_next   = '0;
      tag_next   = '0;
      idx_next   = '0;
      left_next  = '0;
      right_next = '0;
      seen_next  = 1'b0;
    end

    case (sof ? PH_HEADER : phase)
      PH_HEADER: begin
        tag_next = {tag_next[23:0], b};
        if (off_next == RIFF_END_OFS && tag_next != TAG_RIFF) begin
          rej = 1'b1;
        end else if (off_next == WAVE_END_OFS) begin
          if (tag_next != TAG_WAVE) begin
            rej = 1'b1;
          end else begin
            walk = 1'b1;
          end
        end
      end
      PH_CHDR: begin
        if (idx_next < CHDR_TAG_BYTES) begin
          tag_next = {tag_next[23:0], b};
        end else begin
          cbl_next = cbl_next | ({24'd0, b} << {idx_next[1:0], 3'b000});
        end
        idx_next = idx_next + 16'd1;
        if (idx_next == CHDR_BYTES) begin
          idx_next = '0;
          if (tag_next == TAG_FMT && !seen_next) begin
            if (cbl_next < FMT_MIN_BYTES) begin
              rej      = 1'b1;
              rej_code = REJ_FMT_SHORT;
            end else begin
              phase_next = PH_FMT;
            end
          end else if (tag_next == TAG_DATA) begin
            if (!seen_next) begin
              rej      = 1'b1;
              rej_code = REJ_DATA_FIRST;
            end else begin
              // byte count kept; a frame is last when less than one frame remains
              left_next  = '0;
              right_next = '0;
              phase_next = (cbl_next < {16'd0, align_next}) ? PH_DONE : PH_DATA;
            end
          end else if (({1'b0, next_pos} + {2'b00, cbl_next}) > {2'b00, file_size}) begin
            rej      = 1'b1;
            rej_code = seen_next ? REJ_NO_DATA : REJ_FMT_SHORT;
          end else if (cbl_next == 32'd0) begin
            walk = 1'b1;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        case (idx_next[3:0])
          4'd0:    fmt_tag_next[7:0]   = b;
          4'd1:    fmt_tag_next[15:8]  = b;
          4'd2:    channels_next[7:0]  = b;
          4'd3:    channels_next[15:8] = b;
          4'd4:    rate_next[7:0]      = b;
          4'd5:    rate_next[15:8]     = b;
          4'd6:    rate_next[23:16]    = b;
          4'd7:    rate_next[31:24]    = b;
          4'd12:   align_next[7:0]     = b;
          4'd13:   align_next[15:8]    = b;
          4'd14:   bits_next[7:0]      = b;
          4'd15:   bits_next[15:8]     = b;
          default: ;  // byte rate is not kept
        endcase
        idx_next = idx_next + 16'd1;
        if (idx_next == FMT_BYTES) begin
          idx_next = '0;
          need = {15'd0, (bits_next == DEPTH_8BIT) ? 2'd1 : 2'd2}
               + ((channels_next > 16'd1) ? {4'd0, bits_next[15:3]} : 17'd0);
          rem  = cbl_next - FMT_MIN_BYTES;
          if (fmt_tag_next != FMT_PCM) begin
            rej      = 1'b1;
            rej_code = REJ_NOT_PCM;
          end else if (align_next == 16'd0 || {1'b0, align_next} < need) begin
            rej      = 1'b1;
            rej_code = REJ_BAD_ALIGN;
          end else if (({1'b0, next_pos} + {2'b00, rem} + 34'd8) > {2'b00, file_size}) begin
            rej      = 1'b1;
            rej_code = REJ_NO_DATA;
          end else begin
            seen_next                = 1'b1;
            res_valid                = 1'b1;
            res_data.result_kind     = KIND_FORMAT;
            res_data.sample_rate     = rate_next;
            res_data.channel_count   = channels_next;
            res_data.bits_per_sample = bits_next;
            if (rem == 32'd0) begin
              phase_next = PH_CHDR;
              tag_next   = '0;
              cbl_next   = '0;
            end else begin
              cbl_next   = rem;
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        cbl_next = cbl_next - 32'd1;
        if (cbl_next == 32'd0) begin
          walk = 1'b1;
        end
      end
      PH_DATA: begin
        r   = (channels > 16'd1) ? {3'd0, bits[15:3]} : 16'd0;
        rel = idx_next - r;
        if (idx_next < {14'd0, w}) begin
          if (idx_next[0]) begin
            left_next[15:8] = b;
          end else begin
            left_next[7:0] = b;
          end
        end
        if (idx_next >= r && rel < {14'd0, w}) begin
          if (rel[0]) begin
            right_next[15:8] = b;
          end else begin
            right_next[7:0] = b;
          end
        end
        idx_next = idx_next + 16'd1;
        cbl_next = cbl_next - 32'd1;
        if (!(idx_next < align)) begin
          idx_next              = '0;
          last                  = cbl_next < {16'd0, align};
          res_valid             = 1'b1;
          res_data.result_kind  = KIND_FRAME;
          res_data.left_sample  = to_sample(left_next, is8);
          res_data.right_sample = to_sample(right_next, is8);
          res_data.last_frame   = last;
          if (last) begin
            phase_next = PH_DONE;
          end
        end
      end
      default: ;  // idle or finished: byte dropped
    endcase

    // next chunk header position
    if (walk) begin
      if (walk_fail) begin
        rej      = 1'b1;
        rej_code = seen_next ? REJ_NO_DATA : REJ_FMT_SHORT;
      end else begin
        phase_next = PH_CHDR;
        idx_next   = '0;
        tag_next   = '0;
        cbl_next   = '0;
      end
    end

    if (rej) begin
      res_valid            = 1'b1;
      res_data             = '0;
      res_data.result_kind = KIND_REJECT;
      res_data.reject_code = rej_code;
      phase_next           = PH_DONE;
    end
  end

  assign res = '{valid: held.valid && res_valid, data: res_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg_wr_en) begin
      file_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      seen  <= 1'b0;
    end else if (advance) begin
      phase <= phase_next;
      seen  <= seen_next;
    end
  end

  // cleared on start of file or written from the fmt chunk before use, so no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      file_offset <= off_next;
      cbl         <= cbl_next;
      tag         <= tag_next;
      fmt_tag     <= fmt_tag_next;
      channels    <= channels_next;
      rate        <= rate_next;
      align       <= align_next;
      bits        <= bits_next;
      idx         <= idx_next;
      left_bytes  <= left_next;
      right_bytes <= right_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wpsp_out_stage.sv =====
// Result register of the WAV PCM parser: holds one result beat until taken.
// Depends on wpsp_pkg.
`default_nettype none

module wpsp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wpsp_pkg::result_t load_data,
  input  logic              out_ready,
  output logic              space,
  output logic              out_valid,
  output wpsp_pkg::result_t out_data
);
  import wpsp_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wav_pcm_stream_parser_unit.sv =====
// Top level of the WAV PCM parser: input register, parse step, result register.
// Depends on wpsp_pkg, wpsp_if, wpsp_in_stage, wpsp_core, wpsp_out_stage.
//
//   channel   dir   handshake          beat
//   stream    in    valid/ready        data_byte, start_of_file
//   result    out   valid/ready        kind, samples, last_frame, format, reject_code
//   cfg       in    cfg_wr_en          file_size (cfg_wr_data)
//
// One byte per cycle while the result register is not stalled; a byte is held
// in the input register and its result beat in the result register. The rate is
// set by the combinational parse step in wpsp_core between the two registers.
// Reset (rst, synchronous) empties both registers, sets the parser idle and
// file_size to zero.
// A stalled result holds; the input register takes one more byte only if empty,
// and stream.ready stays low while it is full until the result beat leaves.
`default_nettype none

module wav_pcm_stream_parser_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [31:0]    cfg_wr_data,
  wpsp_byte_if.sink      stream,
  wpsp_result_if.source  result
);
  import wpsp_pkg::*;

  item_t        in_item;
  item_beat_t   held;
  result_beat_t res;
  result_t      out_data;
  logic         advance;
  logic         space;
  logic         in_ready;
  logic         out_valid;

  assign in_item = '{data_byte: stream.data_byte, start_of_file: stream.start_of_file};
  assign stream.ready = in_ready;

  // the held byte is parsed when the result register can take what it gives
  assign advance = held.valid && space;

  wpsp_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_item  (in_item),
    .advance  (advance),
    .in_ready (in_ready),
    .held     (held)
  );

  wpsp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .held        (held),
    .advance     (advance),
    .res         (res)
  );

  wpsp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res.valid),
    .load_data (res.data),
    .out_ready (result.ready),
    .space     (space),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign result.valid           = out_valid;
  assign result.result_kind     = out_data.result_kind;
  assign result.left_sample     = out_data.left_sample;
  assign result.right_sample    = out_data.right_sample;
  assign result.last_frame      = out_data.last_frame;
  assign result.sample_rate     = out_data.sample_rate;
  assign result.channel_count   = out_data.channel_count;
  assign result.bits_per_sample = out_data.bits_per_sample;
  assign result.reject_code     = out_data.reject_code;

endmodule

`default_nettype wire

// ===== hdl/wpsp_checker.sv =====
// Port-level checks of the WAV PCM parser, bound to the top level.
// Depends on wpsp_pkg and wav_pcm_stream_parser_unit_defines.svh.
`default_nettype none
`include "wav_pcm_stream_parser_unit_defines.svh"

module wpsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         result_kind,
  input logic signed [15:0] left_sample,
  input logic signed [15:0] right_sample,
  input logic [31:0]        sample_rate,
  input logic [15:0]        channel_count,
  input logic [15:0]        bits_per_sample,
  input logic [2:0]         reject_code
);
  import wpsp_pkg::*;

  `WPSP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(left_sample) && $stable(reject_code), "result beat changed while stalled")

  `WPSP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "byte refused with empty result register")

  `WPSP_ASSERT_NOW(a_frame_clean, out_valid && result_kind == KIND_FRAME, sample_rate == 32'd0 && channel_count == 16'd0 && bits_per_sample == 16'd0 && reject_code == REJ_NOT_WAVE, "frame beat carries format or reject fields")

  `WPSP_ASSERT_NOW(a_reject_clean, out_valid && result_kind == KIND_REJECT, left_sample == 16'sd0 && right_sample == 16'sd0 && sample_rate == 32'd0 && reject_code <= REJ_DATA_FIRST, "bad reject beat")

  `WPSP_ASSERT_NOW(a_quiet_after_reset, $past(rst), !out_valid, "result beat right after reset")

endmodule

bind wav_pcm_stream_parser_unit wpsp_checker u_wpsp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (stream.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .result_kind     (result.result_kind),
  .left_sample     (result.left_sample),
  .right_sample    (result.right_sample),
  .sample_rate     (result.sample_rate),
  .channel_count   (result.channel_count),
  .bits_per_sample (result.bits_per_sample),
  .reject_code     (result.reject_code)
);

`default_nettype wire
